// ===== src/flow_color_wheel_coder_macros.svh =====
// flow_color_wheel_coder_macros.svh: assertion macros for the color wheel coder
// depends on: a clk and rst signal in the scope that uses them
`ifndef FLOW_COLOR_WHEEL_CODER_MACROS_SVH
`define FLOW_COLOR_WHEEL_CODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCWC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcwc assertion failed");

// next-cycle implication, checked outside reset
`define FCWC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcwc assertion failed");

`endif

// ===== src/fcwc_pkg.sv =====
// fcwc_pkg.sv: constants, kind codes, wheel and arctangent tables
// depends on: nothing
package fcwc_pkg;

  localparam int WHEEL_ENTRIES = 55;
  localparam int CORDIC_STEPS  = 28;

  localparam logic [1:0] KIND_MEASURE  = 2'd0;
  localparam logic [1:0] KIND_SPATIAL  = 2'd1;
  localparam logic [1:0] KIND_TEMPORAL = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  localparam logic MODE_SQRT = 1'b0;
  localparam logic MODE_DIV  = 1'b1;

  // arctangent of 2^-i in units of 1/2^32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // wheel entry packed as {blue, green, red}
  function automatic logic [23:0] wheel_bgr(input logic [5:0] idx);
    logic [23:0] r;
    unique case (idx)
      6'd0:  r = {8'd0, 8'd0, 8'd255};
      6'd1:  r = {8'd0, 8'd17, 8'd255};
      6'd2:  r = {8'd0, 8'd34, 8'd255};
      6'd3:  r = {8'd0, 8'd51, 8'd255};
      6'd4:  r = {8'd0, 8'd68, 8'd255};
      6'd5:  r = {8'd0, 8'd85, 8'd255};
      6'd6:  r = {8'd0, 8'd102, 8'd255};
      6'd7:  r = {8'd0, 8'd119, 8'd255};
      6'd8:  r = {8'd0, 8'd136, 8'd255};
      6'd9:  r = {8'd0, 8'd153, 8'd255};
      6'd10: r = {8'd0, 8'd170, 8'd255};
      6'd11: r = {8'd0, 8'd187, 8'd255};
      6'd12: r = {8'd0, 8'd204, 8'd255};
      6'd13: r = {8'd0, 8'd221, 8'd255};
      6'd14: r = {8'd0, 8'd238, 8'd255};
      6'd15: r = {8'd0, 8'd255, 8'd255};
      6'd16: r = {8'd0, 8'd255, 8'd213};
      6'd17: r = {8'd0, 8'd255, 8'd170};
      6'd18: r = {8'd0, 8'd255, 8'd128};
      6'd19: r = {8'd0, 8'd255, 8'd85};
      6'd20: r = {8'd0, 8'd255, 8'd43};
      6'd21: r = {8'd0, 8'd255, 8'd0};
      6'd22: r = {8'd63, 8'd255, 8'd0};
      6'd23: r = {8'd127, 8'd255, 8'd0};
      6'd24: r = {8'd191, 8'd255, 8'd0};
      6'd25: r = {8'd255, 8'd255, 8'd0};
      6'd26: r = {8'd255, 8'd232, 8'd0};
      6'd27: r = {8'd255, 8'd209, 8'd0};
      6'd28: r = {8'd255, 8'd186, 8'd0};
      6'd29: r = {8'd255, 8'd163, 8'd0};
      6'd30: r = {8'd255, 8'd140, 8'd0};
      6'd31: r = {8'd255, 8'd116, 8'd0};
      6'd32: r = {8'd255, 8'd93, 8'd0};
      6'd33: r = {8'd255, 8'd70, 8'd0};
      6'd34: r = {8'd255, 8'd47, 8'd0};
      6'd35: r = {8'd255, 8'd24, 8'd0};
      6'd36: r = {8'd255, 8'd0, 8'd0};
      6'd37: r = {8'd255, 8'd0, 8'd19};
      6'd38: r = {8'd255, 8'd0, 8'd39};
      6'd39: r = {8'd255, 8'd0, 8'd58};
      6'd40: r = {8'd255, 8'd0, 8'd78};
      6'd41: r = {8'd255, 8'd0, 8'd98};
      6'd42: r = {8'd255, 8'd0, 8'd117};
      6'd43: r = {8'd255, 8'd0, 8'd137};
      6'd44: r = {8'd255, 8'd0, 8'd156};
      6'd45: r = {8'd255, 8'd0, 8'd176};
      6'd46: r = {8'd255, 8'd0, 8'd196};
      6'd47: r = {8'd255, 8'd0, 8'd215};
      6'd48: r = {8'd255, 8'd0, 8'd235};
      6'd49: r = {8'd255, 8'd0, 8'd255};
      6'd50: r = {8'd213, 8'd0, 8'd255};
      6'd51: r = {8'd170, 8'd0, 8'd255};
      6'd52: r = {8'd128, 8'd0, 8'd255};
      6'd53: r = {8'd85, 8'd0, 8'd255};
      6'd54: r = {8'd43, 8'd0, 8'd255};
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/fcwc_if.sv =====
// fcwc_if.sv: valid/ready channel interfaces for motion vectors and colors
// depends on: nothing
interface fcwc_flow_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [15:0] flow_u;
  logic signed [15:0] flow_v;
  logic signed [15:0] flow_w;
  modport source (output valid, kind, flow_u, flow_v, flow_w, input ready);
  modport sink (input valid, kind, flow_u, flow_v, flow_w, output ready);
endinterface

interface fcwc_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       beyond_range;
  modport source (output valid, blue, green, red, beyond_range, input ready);
  modport sink (input valid, blue, green, red, beyond_range, output ready);
endinterface

// ===== src/fcwc_cordic.sv =====
// fcwc_cordic.sv: iterative cordic vectoring unit, one micro-rotation per cycle
// depends on: fcwc_pkg (arctangent table, step count)
module fcwc_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  output logic               busy,
  output logic [31:0]        phase
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic [31:0]        z;
  logic [4:0]         idx;
  logic               on_axis;
  logic signed [33:0] px_sc;
  logic signed [33:0] py_sc;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] y_neg;

  assign px_sc = 34'(px) <<< 14;
  assign py_sc = 34'(py) <<< 14;

  // x stays non-negative; y shifts truncate toward zero
  assign xs    = x >>> idx;
  assign y_neg = -y;
  assign ys    = y[33] ? -(y_neg >>> idx) : (y >>> idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      idx     <= '0;
      on_axis <= (py == 16'sd0) && !px[15];
      if (px[15]) begin
        x <= -px_sc;
        y <= -py_sc;
        z <= 32'h8000_0000;
      end else begin
        x <= px_sc;
        y <= py_sc;
        z <= 32'h0;
      end
    end else if (busy) begin
      // rotate toward the positive x axis
      if (!y[33] && (y != 34'sd0)) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + fcwc_pkg::atan_turns(idx);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - fcwc_pkg::atan_turns(idx);
      end
      if (idx == 5'(fcwc_pkg::CORDIC_STEPS - 1)) busy <= 1'b0;
      idx <= idx + 5'd1;
    end
  end

  assign phase = on_axis ? 32'h0 : z;

endmodule

// ===== src/fcwc_sqdiv.sv =====
// fcwc_sqdiv.sv: shared compare/subtract unit for square root and division
// depends on: fcwc_pkg (mode codes)
module fcwc_sqdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        mode,
  input  logic [63:0] operand,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] result,
  output logic        rem_nz
);

  logic [5:0]  count;
  logic        mode_r;
  logic [63:0] shreg;
  logic [33:0] rem;
  logic [15:0] div_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [34:0] diff;
  logic        ge;

  assign busy = (count != 6'd0);

  // sqrt takes two radicand bits per step, division one dividend bit
  always_comb begin
    if (mode_r == fcwc_pkg::MODE_SQRT) begin
      rem_sh = {rem[32:0], shreg[63:62]};
      trial  = {1'b0, result, 2'b01};
    end else begin
      rem_sh = {rem, shreg[63]};
      trial  = {19'd0, div_r};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count  <= 6'd32;
      mode_r <= mode;
      shreg  <= operand;
      div_r  <= divisor;
      rem    <= '0;
      result <= '0;
    end else if (busy) begin
      count  <= count - 6'd1;
      rem    <= ge ? diff[33:0] : rem_sh[33:0];
      result <= {result[30:0], ge};
      shreg  <= (mode_r == fcwc_pkg::MODE_SQRT) ? (shreg << 2) : (shreg << 1);
    end
  end

  assign rem_nz = (rem != 34'd0);

endmodule

// ===== src/flow_color_wheel_coder.sv =====
// A paint item's color comes from a 32-step square root and a 32-step division
// sharing one subtract unit (the 28-step cordic runs beside the root);
// beyond-range items skip the division.
// Items are taken one at a time: flow.ready is high only while the sequencer is idle.
// Reset (rst, synchronous): measured ranges and max_amplitude clear to zero,
// sequencer goes idle, no color pending.
// depends on: fcwc_pkg, fcwc_if, fcwc_cordic, fcwc_sqdiv, macros header
`include "flow_color_wheel_coder_macros.svh"

module flow_color_wheel_coder (
  input  logic              clk,
  input  logic              rst,
  fcwc_flow_if.sink         flow,
  fcwc_color_if.source      color,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_MROOT = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_CWAIT = 4'd8;
  localparam logic [3:0] S_PHASE = 4'd9;
  localparam logic [3:0] S_IDX   = 4'd10;
  localparam logic [3:0] S_BLEND = 4'd11;
  localparam logic [3:0] S_SCALE = 4'd12;
  localparam logic [3:0] S_STORE = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0]         state;
  logic [7:0]         max_amplitude;
  logic [15:0]        largest_radius;
  logic [15:0]        largest_time_magnitude;
  logic [1:0]         kind_r;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [15:0]        aw;
  logic [31:0]        s_part;
  logic [31:0]        s;
  logic               beyond;
  logic [16:0]        rad;
  logic [5:0]         k0;
  logic [15:0]        f;
  logic [1:0]         ch;
  logic [23:0]        b;
  logic [7:0]         chan_b;
  logic [7:0]         chan_g;
  logic [7:0]         chan_r;
  logic               out_valid;
  logic [7:0]         out_blue;
  logic [7:0]         out_green;
  logic [7:0]         out_red;
  logic               out_beyond;
  logic [56:0]        prod;
  logic [31:0]        mul_a;
  logic [24:0]        mul_b;

  logic [15:0]        rng_raw;
  logic [15:0]        range;
  logic [16:0]        w_abs;
  logic [15:0]        u_abs;
  logic [15:0]        v_abs;
  logic [15:0]        meas_r;
  logic               accept;
  logic               emit;

  logic               sd_start;
  logic               sd_mode;
  logic [63:0]        sd_operand;
  logic               sd_busy;
  logic [31:0]        sd_result;
  logic               sd_rem_nz;
  logic               cd_start;
  logic               cd_busy;
  logic [31:0]        cd_phase;

  logic [5:0]         k1;
  logic [23:0]        e0;
  logic [23:0]        e1;
  logic [7:0]         c0;
  logic [7:0]         c1;
  logic [16:0]        f_inv;
  logic [24:0]        blend;
  logic [23:0]        b_gap;
  logic [25:0]        dim3;
  logic [39:0]        lit;
  logic [7:0]         byte_val;

  assign flow.ready = (state == S_IDLE);
  assign accept     = flow.valid && flow.ready;
  assign emit       = (state == S_EMIT) && (!out_valid || color.ready);

  // magnitudes of the incoming components
  assign u_abs = flow.flow_u[15] ? 16'(-flow.flow_u) : 16'(flow.flow_u);
  assign v_abs = flow.flow_v[15] ? 16'(-flow.flow_v) : 16'(flow.flow_v);
  assign w_abs = flow.flow_w[15] ? -17'(flow.flow_w) : 17'(flow.flow_w);

  // normalization range for the current paint item
  always_comb begin
    if (max_amplitude != 8'd0) rng_raw = {max_amplitude, 8'd0};
    else if (kind_r == fcwc_pkg::KIND_SPATIAL) rng_raw = largest_radius;
    else rng_raw = largest_time_magnitude;
    range = (rng_raw == 16'd0) ? 16'd256 : rng_raw;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) max_amplitude <= 8'd0;
    else if (cfg_write) max_amplitude <= cfg_data;
  end

  // shared multiplier operand select, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX:   begin mul_a = 32'(ax);    mul_b = 25'(ax);    end
      S_SQY:   begin mul_a = 32'(ay);    mul_b = 25'(ay);    end
      S_SUM:   begin mul_a = 32'(range); mul_b = 25'(range); end
      S_PHASE: begin mul_a = cd_phase;   mul_b = 25'(fcwc_pkg::WHEEL_ENTRIES - 1); end
      S_SCALE: begin mul_a = 32'(rad);   mul_b = 25'(b_gap); end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 57'(mul_a) * 57'(mul_b);
  end

  // root/divide and cordic launches
  always_comb begin
    sd_start   = 1'b0;
    sd_mode    = fcwc_pkg::MODE_SQRT;
    sd_operand = {32'd0, s};
    cd_start   = 1'b0;
    if (state == S_CMP) begin
      sd_start = 1'b1;
      if (kind_r != fcwc_pkg::KIND_MEASURE) begin
        sd_operand = {s, 32'd0};
        cd_start   = 1'b1;
      end
    end else if (state == S_ROOT && !sd_busy && !beyond) begin
      sd_start   = 1'b1;
      sd_mode    = fcwc_pkg::MODE_DIV;
      sd_operand = {sd_result, 32'd0};
    end
  end

  fcwc_sqdiv u_sqdiv (
    .clk     (clk),
    .rst     (rst),
    .start   (sd_start),
    .mode    (sd_mode),
    .operand (sd_operand),
    .divisor (range),
    .busy    (sd_busy),
    .result  (sd_result),
    .rem_nz  (sd_rem_nz)
  );

  fcwc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .px    (vx),
    .py    (vy),
    .busy  (cd_busy),
    .phase (cd_phase)
  );

  // wheel lookup and linear blend of the selected channel
  assign k1    = (k0 == 6'(fcwc_pkg::WHEEL_ENTRIES - 1)) ? 6'd0 : k0 + 6'd1;
  assign e0    = fcwc_pkg::wheel_bgr(k0);
  assign e1    = fcwc_pkg::wheel_bgr(k1);
  always_comb begin
    unique case (ch)
      2'd0:    begin c0 = e0[23:16]; c1 = e1[23:16]; end
      2'd1:    begin c0 = e0[15:8];  c1 = e1[15:8];  end
      default: begin c0 = e0[7:0];   c1 = e1[7:0];   end
    endcase
  end
  assign f_inv = 17'h10000 - {1'b0, f};
  assign blend = 25'(c0) * 25'(f_inv) + 25'(c1) * 25'(f);
  assign b_gap = 24'd16711680 - b;

  // final byte: dimmed outside the unit radius, desaturated inside
  assign dim3     = 26'(b) * 26'd3;
  assign lit      = 40'hFF_0000_0000 - prod[39:0];
  assign byte_val = beyond ? dim3[25:18] : lit[39:32];

  assign meas_r = sd_result[15:0] + 16'(sd_rem_nz);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= S_IDLE;
      largest_radius         <= 16'd0;
      largest_time_magnitude <= 16'd0;
      out_valid              <= 1'b0;
    end else begin
      // output register: load on emit, clear once the transfer completes
      if (emit) out_valid <= 1'b1;
      else if (color.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r <= flow.kind;
            aw     <= w_abs[15:0];
            if (flow.kind == fcwc_pkg::KIND_CLEAR) begin
              largest_radius         <= 16'd0;
              largest_time_magnitude <= 16'd0;
            end else begin
              if (flow.kind == fcwc_pkg::KIND_TEMPORAL) begin
                vx <= flow.flow_w;
                vy <= flow.flow_w;
                ax <= w_abs[15:0];
                ay <= w_abs[15:0];
              end else begin
                vx <= flow.flow_u;
                vy <= flow.flow_v;
                ax <= u_abs;
                ay <= v_abs;
              end
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          s_part <= prod[31:0];
          state  <= S_SUM;
        end
        S_SUM: begin
          s     <= s_part + prod[31:0];
          state <= S_CMP;
        end
        S_CMP: begin
          beyond <= (s > prod[31:0]);
          rad    <= 17'd0;
          state  <= (kind_r == fcwc_pkg::KIND_MEASURE) ? S_MROOT : S_ROOT;
        end
        S_MROOT: begin
          if (!sd_busy) begin
            if (meas_r > largest_radius) largest_radius <= meas_r;
            if (aw > largest_time_magnitude) largest_time_magnitude <= aw;
            state <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (!sd_busy) state <= beyond ? S_CWAIT : S_DIV;
        end
        S_DIV: begin
          if (!sd_busy) begin
            rad   <= (sd_result > 32'd65536) ? 17'h10000 : sd_result[16:0];
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (!cd_busy) state <= S_PHASE;
        end
        S_PHASE: state <= S_IDX;
        S_IDX: begin
          k0    <= prod[37:32];
          f     <= prod[31:16];
          ch    <= 2'd0;
          state <= S_BLEND;
        end
        S_BLEND: begin
          b     <= blend[23:0];
          state <= S_SCALE;
        end
        S_SCALE: state <= S_STORE;
        S_STORE: begin
          unique case (ch)
            2'd0:    chan_b <= byte_val;
            2'd1:    chan_g <= byte_val;
            default: chan_r <= byte_val;
          endcase
          if (ch == 2'd2) begin
            state <= S_EMIT;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_BLEND;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_blue   <= chan_b;
            out_green  <= chan_g;
            out_red    <= chan_r;
            out_beyond <= beyond;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign color.valid        = out_valid;
  assign color.blue         = out_blue;
  assign color.green        = out_green;
  assign color.red          = out_red;
  assign color.beyond_range = out_beyond;

  // shared unit only runs while the sequencer waits on it
  `FCWC_ASSERT_NOW(a_sqdiv_owned, sd_busy, (state == S_MROOT) || (state == S_ROOT) || (state == S_DIV))
  // cordic only runs while the sequencer is in the root, divide or cordic-wait step
  `FCWC_ASSERT_NOW(a_cordic_owned, cd_busy, (state == S_ROOT) || (state == S_DIV) || (state == S_CWAIT))
  // a new color only leaves the emit step
  `FCWC_ASSERT_NEXT(a_emit_source, !out_valid && (state != S_EMIT), !out_valid)

endmodule
